FILE: rtl/bpe_pkg.sv
// shared types, widths and codes of the breakpoint envelope generator
// no dependencies; every rtl file refers to this package by scoped names
`default_nettype none

package bpe_pkg;

  localparam int MAX_POINTS = 32;
  localparam int PT_AW      = $clog2(MAX_POINTS);

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 5;
  localparam int TIME_W  = 20;
  localparam int LEVEL_W = 7;
  localparam int TS_W    = 17;
  localparam int NP_W    = 6;
  localparam int TICK_W  = 24;
  localparam int SEG_W   = 6;
  localparam int ACC_W   = 32;
  localparam int OUT_W   = 16;

  localparam int FRAC_SH    = 16;
  localparam int STRETCH_SH = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STRETCH = 2'd1;

  localparam logic [NP_W-1:0]    NUM_POINTS_RST   = 6'd2;
  localparam logic [TS_W-1:0]    TIME_STRETCH_RST = 17'd4096;
  localparam logic [TIME_W-1:0]  HOLD_TIME        = 20'd442000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 7'd100;
  localparam logic [OUT_W-1:0]   OUT_MAX          = 16'd32768;
  localparam int                 OUT_SCALE        = 200;

  localparam int DIV_N_W = ACC_W;
  localparam int DIV_D_W = TICK_W;
  localparam int MUL_P_W = TIME_W + TS_W + 2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   point_index;
    logic [TIME_W-1:0]  point_time;
    logic [LEVEL_W-1:0] point_level;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] env_level;
    logic             env_active;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  pt_time;
    logic [LEVEL_W-1:0] pt_level;
  } pt_word_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] multiplicand;
    logic [TS_W-1:0]   multiplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] value;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_LAST_GO,
    ST_LAST_WAIT,
    ST_RD_START,
    ST_RD_END,
    ST_NEXT_GO,
    ST_NEXT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT_CALC,
    ST_OUT_WAIT,
    ST_OUT_HOLD
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/bpe_mul.sv
// bit-serial time stretch: ceil(t * stretch / 4096), saturated to 24 bits
// one multiplier bit per cycle, lsb first; uses bpe_pkg
`default_nettype none

module bpe_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bpe_pkg::mul_req_t req_i,
  output bpe_pkg::mul_rsp_t      rsp_o
);

  localparam int CNT_W = $clog2(bpe_pkg::TS_W);
  localparam int LO_W  = bpe_pkg::TS_W;
  localparam int HI_W  = bpe_pkg::MUL_P_W - LO_W;
  localparam int SAT_B = bpe_pkg::STRETCH_SH + bpe_pkg::TICK_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bpe_pkg::TS_W - 1);
  // rounding constant sits where the first partial product lands
  localparam logic [bpe_pkg::MUL_P_W-1:0] ROUND_INIT =
    bpe_pkg::MUL_P_W'(2 ** bpe_pkg::STRETCH_SH - 1) << LO_W;

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [bpe_pkg::TIME_W-1:0]    mcand_q;
  logic [bpe_pkg::TS_W-1:0]      mplier_q;
  logic [bpe_pkg::MUL_P_W-1:0]   prod_q;
  logic [HI_W-1:0]               sum;

  assign sum = prod_q[bpe_pkg::MUL_P_W-1:LO_W] + (mplier_q[0] ? HI_W'(mcand_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prod_q   <= {1'b0, sum, prod_q[LO_W-1:1]};
      mplier_q <= mplier_q >> 1;
    end else if (req_i.start) begin
      prod_q   <= ROUND_INIT;
      mcand_q  <= req_i.multiplicand;
      mplier_q <= req_i.multiplier;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = (|prod_q[bpe_pkg::MUL_P_W-1:SAT_B]) ? '1
                                                           : prod_q[SAT_B-1:bpe_pkg::STRETCH_SH];

endmodule

`default_nettype wire

FILE: rtl/bpe_div.sv
// bit-serial restoring divider, one quotient bit per cycle, msb first
// shared by the segment slope and the output scaling; uses bpe_pkg
`default_nettype none

module bpe_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bpe_pkg::div_req_t req_i,
  output bpe_pkg::div_rsp_t      rsp_o
);

  localparam int NW    = bpe_pkg::DIV_N_W;
  localparam int DW    = bpe_pkg::DIV_D_W;
  localparam int CNT_W = $clog2(NW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NW-1:0]    quo_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    dvs_q;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             fits;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = !diff[DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fits};
    end else if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/breakpoint_envelope_generator.sv
// Piecewise linear breakpoint envelope built on bpe_pkg, bpe_mul and bpe_div. One request
// is taken at a time and always yields one result. Loads, restarts and ticks inside a
// segment are paced by the serial division that scales the level to Q1.15; when the
// envelope is inactive or the level is not positive that division is skipped. A tick
// that starts a segment first runs two serial multiplies for the stretched times and a
// serial division for the slope, with point table reads in between. A finished result
// waits in an output register, so the next request is taken while it is still pending.
`default_nettype none

module breakpoint_envelope_generator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire bpe_pkg::in_item_t                  in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output bpe_pkg::out_item_t                      out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bpe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bpe_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  bpe_pkg::state_e state_q, state_d;

  logic [bpe_pkg::NP_W-1:0]    num_points_q;
  logic [bpe_pkg::TS_W-1:0]    time_stretch_q;

  logic [bpe_pkg::TICK_W-1:0]  tick_q;
  logic [bpe_pkg::SEG_W-1:0]   seg_q;
  logic [bpe_pkg::TICK_W-1:0]  next_time_q;
  logic [bpe_pkg::ACC_W-1:0]   acc_q;
  logic [bpe_pkg::ACC_W-1:0]   step_q;
  logic                        active_q;

  bpe_pkg::pt_word_t           mem_q [bpe_pkg::MAX_POINTS];
  bpe_pkg::pt_word_t           rd_q;
  logic [bpe_pkg::PT_AW-1:0]   rd_addr;

  logic [bpe_pkg::TICK_W-1:0]  last_q;
  logic [bpe_pkg::LEVEL_W-1:0] start_lvl_q;
  logic [bpe_pkg::LEVEL_W-1:0] end_lvl_q;
  logic [bpe_pkg::OUT_W-1:0]   res_level_q;

  logic                        out_valid_q;
  bpe_pkg::out_item_t          out_data_q;
  logic                        out_load;

  bpe_pkg::mul_req_t           mul_req;
  bpe_pkg::mul_rsp_t           mul_rsp;
  bpe_pkg::div_req_t           div_req;
  bpe_pkg::div_rsp_t           div_rsp;

  logic                        in_acc;
  logic                        seg_tick;
  logic [bpe_pkg::NP_W-1:0]    np_m1;
  logic [bpe_pkg::PT_AW-1:0]   last_idx;
  logic                        has_next;
  logic [bpe_pkg::PT_AW-1:0]   start_idx;
  logic [bpe_pkg::PT_AW-1:0]   next_idx;
  logic [bpe_pkg::LEVEL_W-1:0] lvl_sat;
  logic [bpe_pkg::ACC_W:0]     acc_sum;
  logic [bpe_pkg::ACC_W-1:0]   acc_sat;
  logic [bpe_pkg::TICK_W-1:0]  tick_inc;
  logic [bpe_pkg::SEG_W-1:0]   seg_inc;
  logic [bpe_pkg::TICK_W-1:0]  dt;
  logic                        step_neg;
  logic [bpe_pkg::LEVEL_W-1:0] step_mag;
  logic                        show_zero;

  assign in_ready_o  = (state_q == bpe_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a tick at or past the next point time starts a segment while the envelope is active
  assign seg_tick = (in_data_i.cmd == bpe_pkg::CMD_TICK) && active_q && !(tick_q < next_time_q);

  // points in use, clamped to 1..MAX_POINTS, as the index of the last one
  assign np_m1 = num_points_q - bpe_pkg::NP_W'(1);
  always_comb begin
    if (num_points_q == '0) begin
      last_idx = '0;
    end else if (int'(num_points_q) > bpe_pkg::MAX_POINTS) begin
      last_idx = bpe_pkg::PT_AW'(bpe_pkg::MAX_POINTS - 1);
    end else begin
      last_idx = bpe_pkg::PT_AW'(np_m1);
    end
  end

  assign has_next  = seg_q < bpe_pkg::SEG_W'(last_idx);
  assign start_idx = has_next ? bpe_pkg::PT_AW'(seg_q) : last_idx;
  assign next_idx  = bpe_pkg::PT_AW'(seg_q + 1'b1);

  assign lvl_sat = (in_data_i.point_level > bpe_pkg::LEVEL_MAX) ? bpe_pkg::LEVEL_MAX
                                                                 : in_data_i.point_level;

  assign acc_sum = {acc_q[bpe_pkg::ACC_W-1], acc_q} + {step_q[bpe_pkg::ACC_W-1], step_q};
  assign acc_sat = (acc_sum[bpe_pkg::ACC_W] != acc_sum[bpe_pkg::ACC_W-1])
                 ? {acc_sum[bpe_pkg::ACC_W], {(bpe_pkg::ACC_W-1){~acc_sum[bpe_pkg::ACC_W]}}}
                 : acc_sum[bpe_pkg::ACC_W-1:0];

  assign tick_inc = (tick_q == '1) ? tick_q : tick_q + 1'b1;
  assign seg_inc  = (seg_q == '1) ? seg_q : seg_q + 1'b1;

  assign dt       = (next_time_q > tick_q) ? next_time_q - tick_q : bpe_pkg::TICK_W'(1);
  assign step_neg = end_lvl_q < start_lvl_q;
  assign step_mag = step_neg ? start_lvl_q - end_lvl_q : end_lvl_q - start_lvl_q;

  assign show_zero = !active_q || acc_q[bpe_pkg::ACC_W-1] || (acc_q == '0);

  bpe_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  bpe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q   <= bpe_pkg::NUM_POINTS_RST;
      time_stretch_q <= bpe_pkg::TIME_STRETCH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == bpe_pkg::REG_NUM_POINTS) begin
        num_points_q <= cfg_data_i[bpe_pkg::NP_W-1:0];
      end else if (cfg_index_i == bpe_pkg::REG_TIME_STRETCH) begin
        time_stretch_q <= cfg_data_i[bpe_pkg::TS_W-1:0];
      end
    end
  end

  // point table
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.cmd == bpe_pkg::CMD_LOAD) &&
        (int'(in_data_i.point_index) < bpe_pkg::MAX_POINTS)) begin
      mem_q[bpe_pkg::PT_AW'(in_data_i.point_index)] <= '{pt_time:  in_data_i.point_time,
                                                         pt_level: lvl_sat};
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    rd_addr  = last_idx;
    out_load = 1'b0;
    mul_req  = '{start: 1'b0, multiplicand: rd_q.pt_time, multiplier: time_stretch_q};
    div_req  = '{start: 1'b0, dividend: acc_q,
                 divisor: bpe_pkg::DIV_D_W'(bpe_pkg::OUT_SCALE)};
    unique case (state_q)
      bpe_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = seg_tick ? bpe_pkg::ST_RD_LAST : bpe_pkg::ST_OUT_CALC;
        end
      end
      bpe_pkg::ST_RD_LAST: begin
        rd_addr = last_idx;
        state_d = bpe_pkg::ST_LAST_GO;
      end
      bpe_pkg::ST_LAST_GO: begin
        mul_req.start = 1'b1;
        state_d       = bpe_pkg::ST_LAST_WAIT;
      end
      bpe_pkg::ST_LAST_WAIT: begin
        if (mul_rsp.done) begin
          state_d = bpe_pkg::ST_RD_START;
        end
      end
      bpe_pkg::ST_RD_START: begin
        rd_addr = start_idx;
        state_d = bpe_pkg::ST_RD_END;
      end
      bpe_pkg::ST_RD_END: begin
        rd_addr = next_idx;
        state_d = bpe_pkg::ST_NEXT_GO;
      end
      bpe_pkg::ST_NEXT_GO: begin
        // past the last point the next time is the held time
        mul_req.start        = 1'b1;
        mul_req.multiplicand = has_next ? rd_q.pt_time : bpe_pkg::HOLD_TIME;
        state_d              = bpe_pkg::ST_NEXT_WAIT;
      end
      bpe_pkg::ST_NEXT_WAIT: begin
        if (mul_rsp.done) begin
          state_d = bpe_pkg::ST_DIV_GO;
        end
      end
      bpe_pkg::ST_DIV_GO: begin
        div_req = '{start: 1'b1,
                    dividend: bpe_pkg::DIV_N_W'(step_mag) << bpe_pkg::FRAC_SH,
                    divisor: dt};
        state_d = bpe_pkg::ST_DIV_WAIT;
      end
      bpe_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = bpe_pkg::ST_OUT_CALC;
        end
      end
      bpe_pkg::ST_OUT_CALC: begin
        if (show_zero) begin
          state_d = bpe_pkg::ST_OUT_HOLD;
        end else begin
          div_req.start = 1'b1;
          state_d       = bpe_pkg::ST_OUT_WAIT;
        end
      end
      bpe_pkg::ST_OUT_WAIT: begin
        if (div_rsp.done) begin
          state_d = bpe_pkg::ST_OUT_HOLD;
        end
      end
      bpe_pkg::ST_OUT_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = bpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpe_pkg::ST_IDLE;
      end
    endcase
  end

  // envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      seg_q       <= '0;
      next_time_q <= '0;
      acc_q       <= '0;
      step_q      <= '0;
      active_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_data_i.cmd == bpe_pkg::CMD_RESTART) begin
          tick_q      <= '0;
          seg_q       <= '0;
          next_time_q <= '0;
          active_q    <= 1'b1;
        end else if ((in_data_i.cmd == bpe_pkg::CMD_TICK) && active_q && !seg_tick) begin
          acc_q  <= acc_sat;
          tick_q <= tick_inc;
        end
      end
      if ((state_q == bpe_pkg::ST_NEXT_WAIT) && mul_rsp.done) begin
        next_time_q <= mul_rsp.value;
      end
      if ((state_q == bpe_pkg::ST_DIV_WAIT) && div_rsp.done) begin
        step_q   <= step_neg ? '0 - div_rsp.quotient : div_rsp.quotient;
        acc_q    <= bpe_pkg::ACC_W'(start_lvl_q) << bpe_pkg::FRAC_SH;
        seg_q    <= seg_inc;
        active_q <= tick_q < last_q;
        tick_q   <= tick_inc;
      end
    end
  end

  // segment operands and result level
  always_ff @(posedge clk_i) begin
    if ((state_q == bpe_pkg::ST_LAST_WAIT) && mul_rsp.done) begin
      last_q <= mul_rsp.value;
    end
    if (state_q == bpe_pkg::ST_RD_END) begin
      start_lvl_q <= rd_q.pt_level;
    end
    if (state_q == bpe_pkg::ST_NEXT_GO) begin
      end_lvl_q <= has_next ? rd_q.pt_level : start_lvl_q;
    end
    if ((state_q == bpe_pkg::ST_OUT_CALC) && show_zero) begin
      res_level_q <= '0;
    end else if ((state_q == bpe_pkg::ST_OUT_WAIT) && div_rsp.done) begin
      res_level_q <= (div_rsp.quotient > bpe_pkg::DIV_N_W'(bpe_pkg::OUT_MAX))
                   ? bpe_pkg::OUT_MAX : div_rsp.quotient[bpe_pkg::OUT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= '{env_level: res_level_q, env_active: active_q};
    end
  end

  a_level_zero_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.env_active |-> out_data_o.env_level == '0)
    else $error("inactive result with nonzero level");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.env_level <= bpe_pkg::OUT_MAX)
    else $error("result level above full scale");

  a_active_on_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(active_q) |-> $past(in_acc && (in_data_i.cmd == bpe_pkg::CMD_RESTART)))
    else $error("envelope armed without a restart request");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> div_req.divisor != '0)
    else $error("division started with zero divisor");

endmodule

`default_nettype wire
